// ===== src/bet_pkg.sv =====
// ----------------------------------------------------------------------------
// bet_pkg
// Shared types and constants of the Bezier easing table builder.
// ----------------------------------------------------------------------------
package bet_pkg;

   localparam int DEF_TABLE_SIZE       = 32;
   localparam int DEF_MAX_NEWTON_STEPS = 16;

   localparam int CTRL_W   = 7;
   localparam int VALUE_W  = 17;
   localparam int INDEX_W  = 6;
   localparam int STEP_W   = 5;
   localparam int DIV_STEPS = 48;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [1:0] {
      POLY_X,
      POLY_S,
      POLY_Y
   } poly_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SETUP_P,
      OP_SETUP_C,
      OP_INIT_T,
      OP_LOAD,
      OP_MUL,
      OP_ADD,
      OP_RESID,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_NEXT,
      OP_OUT_SAMPLE,
      OP_OUT_LINEAR,
      OP_OUT_FINAL
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      poly_type   poly;
      logic [1:0] pstep;
      logic       conv;
   } dp_cmd_type;

   typedef struct packed {
      logic linear;
      logic resid_small;
      logic slope_zero;
      logic last_sample;
   } dp_status_type;

endpackage

// ===== src/bezier_easing_table_builder.sv =====
// ----------------------------------------------------------------------------
// bezier_easing_table_builder
// Builds a cubic Bezier easing table by Newton iteration in Q2.16.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_ctrl_x1, _y1, _x2, _y2
// rsp      out        rsp_valid/rsp_stall   rsp_sample_value, _index, flags
//
// One curve at a time; req_stall is high until its last transfer is taken.
// Per sample: a start step, then per Newton step x(t) and its check, the slope,
// the serial divider and the update; the closing x(t) check is followed by
// y(t) and output, then the index advances after the transfer.
// A linear curve skips the iteration; its result is registered in S_SETUP_P.
// Reset is synchronous, active high. A stalled result holds the block in place.
// ----------------------------------------------------------------------------
module bezier_easing_table_builder import bet_pkg::*; #(
   parameter int TABLE_SIZE       = DEF_TABLE_SIZE,
   parameter int MAX_NEWTON_STEPS = DEF_MAX_NEWTON_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CTRL_W-1:0]  req_ctrl_x1,
   input  logic [CTRL_W-1:0]  req_ctrl_y1,
   input  logic [CTRL_W-1:0]  req_ctrl_x2,
   input  logic [CTRL_W-1:0]  req_ctrl_y2,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_sample_value,
   output logic [INDEX_W-1:0] rsp_sample_index,
   output logic               rsp_is_linear,
   output logic               rsp_converged,
   output logic               rsp_last_entry
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bet_ctrl #(
      .MAX_NEWTON_STEPS(MAX_NEWTON_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bet_datapath #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_ctrl_x1      (req_ctrl_x1),
      .req_ctrl_y1      (req_ctrl_y1),
      .req_ctrl_x2      (req_ctrl_x2),
      .req_ctrl_y2      (req_ctrl_y2),
      .cmd              (cmd),
      .status           (status),
      .rsp_sample_value (rsp_sample_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_is_linear    (rsp_is_linear),
      .rsp_converged    (rsp_converged),
      .rsp_last_entry   (rsp_last_entry)
   );

endmodule

// ===== src/bet_datapath.sv =====
// ----------------------------------------------------------------------------
// bet_datapath
// Coefficients, shared multiply-add unit, serial divider and result register.
// ----------------------------------------------------------------------------
module bet_datapath import bet_pkg::*; #(
   parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CTRL_W-1:0]   req_ctrl_x1,
   input  logic [CTRL_W-1:0]   req_ctrl_y1,
   input  logic [CTRL_W-1:0]   req_ctrl_x2,
   input  logic [CTRL_W-1:0]   req_ctrl_y2,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic [VALUE_W-1:0]  rsp_sample_value,
   output logic [INDEX_W-1:0]  rsp_sample_index,
   output logic                rsp_is_linear,
   output logic                rsp_converged,
   output logic                rsp_last_entry
);

   localparam int UNIT_STEP = 65536 / TABLE_SIZE;
   localparam int UNIT_REM  = 65536 % TABLE_SIZE;

   logic [CTRL_W-1:0]  bx1_ff, by1_ff, bx2_ff, by2_ff;
   logic [16:0]        px1_ff, py1_ff, px2_ff, py2_ff;
   logic signed [19:0] ax_ff, bx_ff, cx_ff, ay_ff, by_ff, cy_ff;
   logic signed [31:0] acc_ff;
   logic signed [51:0] prod_ff;
   logic signed [19:0] t_ff;
   logic [15:0]        u_ff;
   logic [6:0]         rem_ff;
   logic [INDEX_W-1:0] d_ff;
   logic signed [31:0] r_ff;
   logic               neg_ff;
   logic [31:0]        den_ff;
   logic [47:0]        quo_ff;
   logic [31:0]        prem_ff;

   logic signed [31:0] load_val, addend, prod_q, slope_in;
   logic signed [51:0] rnd;
   logic [32:0]        prem_sh;
   logic [32:0]        prem_sub;
   logic [31:0]        r_mag, s_mag;
   logic signed [49:0] q_signed, t_wide;
   logic signed [19:0] t_in;
   logic [6:0]         rem_sum;
   logic [VALUE_W-1:0] y_clamp;

   function automatic logic [16:0] to_q16(input logic [CTRL_W-1:0] v);
      logic [22:0] n;
      logic [48:0] m;
      n = {v, 16'd0} + 23'd63;
      m = 49'(n) * 49'd33818641;
      return m[48:32];
   endfunction

   function automatic logic signed [19:0] coef_a(input logic [16:0] p1, input logic [16:0] p2);
      logic signed [21:0] s;
      s = 22'sd65536 + 22'(p1) * 22'sd3 - 22'(p2) * 22'sd3;
      return s[19:0];
   endfunction

   function automatic logic signed [19:0] coef_b(input logic [16:0] p1, input logic [16:0] p2);
      logic signed [21:0] s;
      s = 22'(p2) * 22'sd3 - 22'(p1) * 22'sd6;
      return s[19:0];
   endfunction

   always_comb begin
      unique case (cmd.poly)
         POLY_X:  load_val = 32'(ax_ff);
         POLY_S:  load_val = 32'(ax_ff) * 32'sd3;
         default: load_val = 32'(ay_ff);
      endcase
      addend = '0;
      unique case (cmd.poly)
         POLY_X: begin
            if (cmd.pstep == 2'd0) addend = 32'(bx_ff);
            else if (cmd.pstep == 2'd1) addend = 32'(cx_ff);
         end
         POLY_S: begin
            if (cmd.pstep == 2'd0) addend = 32'(bx_ff) * 32'sd2;
            else addend = 32'(cx_ff);
         end
         default: begin
            if (cmd.pstep == 2'd0) addend = 32'(by_ff);
            else if (cmd.pstep == 2'd1) addend = 32'(cy_ff);
         end
      endcase
   end

   // round to nearest, ties away from zero
   assign rnd    = prod_ff + 52'sd32768 - 52'(prod_ff[51]);
   assign prod_q = rnd[47:16];
   assign slope_in = prod_q + addend;

   assign prem_sh  = {prem_ff, quo_ff[47]};
   assign prem_sub = prem_sh - {1'b0, den_ff};
   assign r_mag    = r_ff[31] ? 32'(-r_ff) : 32'(r_ff);
   assign s_mag    = acc_ff[31] ? 32'(-acc_ff) : 32'(acc_ff);

   assign q_signed = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   assign t_wide   = 50'(t_ff) - q_signed;

   always_comb begin
      if (t_wide < -50'sd524288) t_in = -20'sd524288;
      else if (t_wide > 50'sd524287) t_in = 20'sd524287;
      else t_in = t_wide[19:0];
   end

   assign rem_sum = rem_ff + 7'(UNIT_REM);

   always_comb begin
      if (acc_ff < 32'sd0) y_clamp = '0;
      else if (acc_ff > 32'sd65536) y_clamp = 17'd65536;
      else y_clamp = acc_ff[16:0];
   end

   assign status.linear      = (bx1_ff == by1_ff) && (bx2_ff == by2_ff);
   assign status.resid_small = (r_ff > -32'sd7) && (r_ff < 32'sd7);
   assign status.slope_zero  = (acc_ff == 32'sd0);
   assign status.last_sample = (d_ff == INDEX_W'(TABLE_SIZE - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff   <= '0;
         u_ff   <= '0;
         rem_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_CAPTURE: begin
               bx1_ff <= req_ctrl_x1;
               by1_ff <= req_ctrl_y1;
               bx2_ff <= req_ctrl_x2;
               by2_ff <= req_ctrl_y2;
            end
            OP_SETUP_P: begin
               px1_ff <= to_q16(bx1_ff);
               py1_ff <= to_q16(by1_ff);
               px2_ff <= to_q16(bx2_ff);
               py2_ff <= to_q16(by2_ff);
            end
            OP_SETUP_C: begin
               ax_ff  <= coef_a(px1_ff, px2_ff);
               bx_ff  <= coef_b(px1_ff, px2_ff);
               cx_ff  <= 20'(px1_ff) * 20'sd3;
               ay_ff  <= coef_a(py1_ff, py2_ff);
               by_ff  <= coef_b(py1_ff, py2_ff);
               cy_ff  <= 20'(py1_ff) * 20'sd3;
               d_ff   <= '0;
               u_ff   <= '0;
               rem_ff <= '0;
            end
            OP_INIT_T:  t_ff <= 20'(u_ff);
            OP_LOAD:    acc_ff <= load_val;
            OP_MUL:     prod_ff <= 52'(acc_ff) * 52'(t_ff);
            OP_ADD:     acc_ff <= slope_in;
            OP_RESID:   r_ff <= acc_ff - 32'(u_ff);
            OP_DIV_START: begin
               quo_ff  <= {r_mag, 16'd0};
               prem_ff <= '0;
               den_ff  <= s_mag;
               neg_ff  <= r_ff[31] ^ acc_ff[31];
            end
            OP_DIV_STEP: begin
               if (prem_sh >= {1'b0, den_ff}) begin
                  prem_ff <= prem_sub[31:0];
                  quo_ff  <= {quo_ff[46:0], 1'b1};
               end else begin
                  prem_ff <= prem_sh[31:0];
                  quo_ff  <= {quo_ff[46:0], 1'b0};
               end
            end
            OP_UPDATE:  t_ff <= t_in;
            OP_NEXT: begin
               d_ff <= d_ff + 1'b1;
               if (rem_sum >= 7'(TABLE_SIZE)) begin
                  rem_ff <= rem_sum - 7'(TABLE_SIZE);
                  u_ff   <= u_ff + 16'(UNIT_STEP + 1);
               end else begin
                  rem_ff <= rem_sum;
                  u_ff   <= u_ff + 16'(UNIT_STEP);
               end
            end
            OP_OUT_SAMPLE: begin
               rsp_sample_value <= y_clamp;
               rsp_sample_index <= d_ff;
               rsp_is_linear    <= 1'b0;
               rsp_converged    <= cmd.conv;
               rsp_last_entry   <= 1'b0;
            end
            OP_OUT_LINEAR: begin
               rsp_sample_value <= '0;
               rsp_sample_index <= '0;
               rsp_is_linear    <= 1'b1;
               rsp_converged    <= 1'b1;
               rsp_last_entry   <= 1'b1;
            end
            OP_OUT_FINAL: begin
               rsp_sample_value <= 17'd65536;
               rsp_sample_index <= INDEX_W'(TABLE_SIZE);
               rsp_is_linear    <= 1'b0;
               rsp_converged    <= 1'b1;
               rsp_last_entry   <= 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== src/bet_ctrl.sv =====
// ----------------------------------------------------------------------------
// bet_ctrl
// Sequencer: Newton loop, polynomial steps, divider count, output handshake.
// ----------------------------------------------------------------------------
module bet_ctrl import bet_pkg::*; #(
   parameter int MAX_NEWTON_STEPS = DEF_MAX_NEWTON_STEPS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP_P,
      S_SETUP_C,
      S_SAMPLE,
      S_LOAD,
      S_MUL,
      S_ADD,
      S_RESID,
      S_CHECK_X,
      S_CHECK_S,
      S_DIVIDE,
      S_UPDATE,
      S_OUT,
      S_WAIT,
      S_NEXT,
      S_FINAL
   } state_type;

   state_type          state_ff;
   poly_type           poly_ff;
   logic [1:0]         pstep_ff;
   logic [STEP_W-1:0]  steps_ff;
   logic [DIV_CNT_W-1:0] divcnt_ff;
   logic               conv_ff;
   logic               last_ff;
   logic               rsp_valid_ff;
   logic               poly_done;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign poly_done = (pstep_ff == ((poly_ff == POLY_S) ? 2'd1 : 2'd2));

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.poly  = poly_ff;
      cmd.pstep = pstep_ff;
      cmd.conv  = conv_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) cmd.op = OP_CAPTURE;
         S_SETUP_P: cmd.op = status.linear ? OP_OUT_LINEAR : OP_SETUP_P;
         S_SETUP_C: cmd.op = OP_SETUP_C;
         S_SAMPLE:  cmd.op = OP_INIT_T;
         S_LOAD:    cmd.op = OP_LOAD;
         S_MUL:     cmd.op = OP_MUL;
         S_ADD:     cmd.op = OP_ADD;
         S_RESID:   cmd.op = OP_RESID;
         S_CHECK_S: if (!status.slope_zero) cmd.op = OP_DIV_START;
         S_DIVIDE:  cmd.op = OP_DIV_STEP;
         S_UPDATE:  cmd.op = OP_UPDATE;
         S_OUT:     cmd.op = OP_OUT_SAMPLE;
         S_NEXT:    cmd.op = OP_NEXT;
         S_FINAL:   cmd.op = OP_OUT_FINAL;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         poly_ff      <= POLY_X;
         pstep_ff     <= '0;
         steps_ff     <= '0;
         divcnt_ff    <= '0;
         conv_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_SETUP_P;
            S_SETUP_P: begin
               if (status.linear) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= 1'b1;
                  state_ff     <= S_WAIT;
               end else begin
                  state_ff <= S_SETUP_C;
               end
            end
            S_SETUP_C: state_ff <= S_SAMPLE;
            S_SAMPLE: begin
               steps_ff <= '0;
               poly_ff  <= POLY_X;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               pstep_ff <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: state_ff <= S_ADD;
            S_ADD: begin
               pstep_ff <= pstep_ff + 1'b1;
               if (!poly_done) state_ff <= S_MUL;
               else begin
                  unique case (poly_ff)
                     POLY_X:  state_ff <= S_RESID;
                     POLY_S:  state_ff <= S_CHECK_S;
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_RESID: state_ff <= S_CHECK_X;
            S_CHECK_X: begin
               priority if (status.resid_small) begin
                  conv_ff  <= 1'b1;
                  poly_ff  <= POLY_Y;
               end else if (steps_ff >= STEP_W'(MAX_NEWTON_STEPS)) begin
                  conv_ff  <= 1'b0;
                  poly_ff  <= POLY_Y;
               end else begin
                  poly_ff  <= POLY_S;
               end
               state_ff <= S_LOAD;
            end
            S_CHECK_S: begin
               if (status.slope_zero) begin
                  conv_ff  <= 1'b0;
                  poly_ff  <= POLY_Y;
                  state_ff <= S_LOAD;
               end else begin
                  divcnt_ff <= '0;
                  state_ff  <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               divcnt_ff <= divcnt_ff + 1'b1;
               if (divcnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               steps_ff <= steps_ff + 1'b1;
               poly_ff  <= POLY_X;
               state_ff <= S_LOAD;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               last_ff      <= 1'b0;
               state_ff     <= S_WAIT;
            end
            S_WAIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  priority if (last_ff) begin
                     last_ff  <= 1'b0;
                     state_ff <= S_IDLE;
                  end else if (status.last_sample) begin
                     state_ff <= S_FINAL;
                  end else begin
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_NEXT: state_ff <= S_SAMPLE;
            S_FINAL: begin
               rsp_valid_ff <= 1'b1;
               last_ff      <= 1'b1;
               state_ff     <= S_WAIT;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
